// File: hw/rtl/qfp_pkg.sv
// qfp_pkg: shared types for the qr function pattern block
// no dependencies; imported by the rtl files
package qfp_pkg;

    localparam int unsigned FormatBits  = 15;
    localparam int unsigned VersionBits = 18;

    // register index on the configuration port, byte address is four times this
    typedef enum logic [2:0] {
        REG_MICRO_MODE     = 3'd0,
        REG_MODULE_COUNT   = 3'd1,
        REG_FORMAT_WORD    = 3'd2,
        REG_VERSION_WORD   = 3'd3,
        REG_VERSION_ENABLE = 3'd4
    } cfg_reg_t;

    // configuration as seen by the pattern logic
    typedef struct packed {
        logic                   micro_mode;
        logic [7:0]             module_count;
        logic [FormatBits-1:0]  format_word;
        logic [VersionBits-1:0] version_word;
        logic                   version_enable;
    } cfg_t;

endpackage

// File: hw/rtl/qr_function_pattern_module.sv
// qr_function_pattern_module: an accepted request is held in the input register, then its result in the result register
// throughput one request per cycle, sustained, with no bubbles under steady ready
// one input register, one pattern evaluation, one result register; a stalled
// result holds the input register and then s_tready drops
// aresetn is synchronous active low: clears valid flags and the configuration
// registers (qr mode, 21 modules, format and version words zero, version off)
module qr_function_pattern_module
    import qfp_pkg::*;
#(
    parameter int unsigned MAX_MODULES = 177
) (
    input  logic        aclk,
    input  logic        aresetn,
    // coordinate request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] first_index, [15:8] second_index
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] module_dark, [7:1] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;

    // input stage
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;

    // result stage
    logic       m_valid_reg, m_valid_next;
    logic       dark_reg, dark_next;

    logic       out_ready;
    logic       stage_fire;
    logic       in_fire;
    logic       dark_comb;

    qfp_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qfp_pattern #(
        .MAX_MODULES (MAX_MODULES)
    ) u_pattern (
        .cfg          (cfg),
        .first_index  (first_reg),
        .second_index (second_reg),
        .module_dark  (dark_comb)
    );

    // result register frees when empty or being taken
    assign out_ready  = !m_valid_reg || m_tready;
    // input register moves into the result register
    assign stage_fire = stage_valid_reg && out_ready;
    // input register takes a new request when empty or draining this cycle
    assign s_tready   = !stage_valid_reg || out_ready;
    assign in_fire    = s_tvalid && s_tready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        if (in_fire) begin
            stage_valid_next = 1'b1;
            first_next       = s_tdata[7:0];
            second_next      = s_tdata[15:8];
        end else if (stage_fire) begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        dark_next    = dark_reg;
        if (stage_fire) begin
            m_valid_next = 1'b1;
            dark_next    = dark_comb;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        second_reg <= second_next;
        dark_reg   <= dark_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, dark_reg};

    // an accepted request always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> stage_valid_reg)
        else $error("accepted request lost before input register");

    // back pressure only when both stages are occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (stage_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled with a free stage");

    // a held input request keeps its coordinate while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && !out_ready) |=>
            (stage_valid_reg && $stable(first_reg) && $stable(second_reg)))
        else $error("stalled request changed in input register");

    // coordinates beyond the symbol give a light module
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_fire && (first_reg >= cfg.module_count || second_reg >= cfg.module_count))
            |=> (m_valid_reg && !dark_reg))
        else $error("module outside symbol reported dark");

endmodule

// File: hw/rtl/qfp_cfg_regs.sv
// qfp_cfg_regs: apb register file for the qr function pattern block
// depends on qfp_pkg (cfg_t, cfg_reg_t)
module qfp_cfg_regs
    import qfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    cfg_reg_t   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = cfg_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_MICRO_MODE:     cfg_next.micro_mode     = pwdata[0];
                REG_MODULE_COUNT:   cfg_next.module_count   = pwdata[7:0];
                REG_FORMAT_WORD:    cfg_next.format_word    = pwdata[FormatBits-1:0];
                REG_VERSION_WORD:   cfg_next.version_word   = pwdata[VersionBits-1:0];
                REG_VERSION_ENABLE: cfg_next.version_enable = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.micro_mode     <= 1'b0;
            cfg_reg.module_count   <= 8'd21;
            cfg_reg.format_word    <= '0;
            cfg_reg.version_word   <= '0;
            cfg_reg.version_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MICRO_MODE:     prdata = {31'd0, cfg_reg.micro_mode};
            REG_MODULE_COUNT:   prdata = {24'd0, cfg_reg.module_count};
            REG_FORMAT_WORD:    prdata = {17'd0, cfg_reg.format_word};
            REG_VERSION_WORD:   prdata = {14'd0, cfg_reg.version_word};
            REG_VERSION_ENABLE: prdata = {31'd0, cfg_reg.version_enable};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/qfp_pattern.sv
// qfp_pattern: combinational function pattern value for one module coordinate
// depends on qfp_pkg (cfg_t); layers applied in order, later layers win
module qfp_pattern
    import qfp_pkg::*;
#(
    parameter int unsigned MAX_MODULES = 177
) (
    input  cfg_t       cfg,
    input  logic [7:0] first_index,
    input  logic [7:0] second_index,
    output logic       module_dark
);

    localparam logic [7:0] MaxCount = 8'(MAX_MODULES);

    logic [7:0]        n_clamp;
    logic signed [9:0] r_s, c_s, n_s;
    logic signed [9:0] far_s, ver_s;
    logic signed [9:0] c_off, r_off, a_c, a_r;
    logic signed [9:0] fmt2_row, fmt2_col;
    logic [4:0]        r3, c3;
    logic [4:0]        vidx_row, vidx_col;
    logic [3:0]        fidx_c1col, fidx_c1row;
    logic              v;

    function automatic logic finder_at(input logic signed [9:0] rr,
                                       input logic signed [9:0] cc);
        logic inside_box;
        logic border;
        logic core;
        inside_box = (rr >= 0) && (rr <= 6) && (cc >= 0) && (cc <= 6);
        border     = (rr == 0) || (rr == 6) || (cc == 0) || (cc == 6);
        core       = (rr >= 2) && (rr <= 4) && (cc >= 2) && (cc <= 4);
        return inside_box && (border || core);
    endfunction

    assign n_clamp = (cfg.module_count > MaxCount) ? MaxCount : cfg.module_count;

    assign r_s   = $signed({2'b00, first_index});
    assign c_s   = $signed({2'b00, second_index});
    assign n_s   = $signed({2'b00, n_clamp});
    assign far_s = n_s - 10'sd7;
    assign ver_s = n_s - 10'sd11;
    assign c_off = c_s - far_s;
    assign r_off = r_s - far_s;
    assign a_c   = c_s - ver_s;
    assign a_r   = r_s - ver_s;

    // second format copy positions
    assign fmt2_row = n_s - 10'sd1 - c_s;
    assign fmt2_col = r_s - n_s + 10'sd15;

    // first format copy, skipping the timing line
    assign fidx_c1col = (first_index < 8'd6) ? first_index[3:0] : first_index[3:0] - 4'd1;
    assign fidx_c1row = (second_index == 8'd7) ? 4'd8 : 4'd14 - second_index[3:0];

    // version bit 17 - (3*i + a)
    assign r3       = ({2'b00, first_index[2:0]} << 1) + {2'b00, first_index[2:0]};
    assign c3       = ({2'b00, second_index[2:0]} << 1) + {2'b00, second_index[2:0]};
    assign vidx_row = 5'd17 - (r3 + {3'b000, a_c[1:0]});
    assign vidx_col = 5'd17 - (c3 + {3'b000, a_r[1:0]});

    always_comb begin
        v = 1'b0;
        if (cfg.micro_mode) begin
            if (finder_at(r_s, c_s)) v = 1'b1;
            if (r_s == 0 && c_s >= 8 && !second_index[0]) v = 1'b1;
            if (c_s == 0 && r_s >= 8 && !first_index[0]) v = 1'b1;
            if (c_s == 8 && r_s >= 1 && r_s <= 8)
                v = cfg.format_word[first_index[3:0] - 4'd1];
            if (r_s == 8 && c_s >= 1 && c_s <= 7)
                v = cfg.format_word[4'd15 - second_index[3:0]];
        end else begin
            if (finder_at(r_s, c_s) || finder_at(r_s, c_off) || finder_at(r_off, c_s))
                v = 1'b1;
            if (c_s == 6 && r_s >= 8 && r_s < n_s - 10'sd8 && !first_index[0]) v = 1'b1;
            if (r_s == 6 && c_s >= 8 && c_s < n_s - 10'sd8 && !second_index[0]) v = 1'b1;
            // dark module
            if (r_s == 8 && c_s == n_s - 10'sd8) v = 1'b1;
            if (c_s == 8 && r_s <= 8 && r_s != 6) v = cfg.format_word[fidx_c1col];
            if (r_s == 8 && c_s <= 7 && c_s != 6) v = cfg.format_word[fidx_c1row];
            if (r_s == 8 && c_s >= far_s && c_s <= n_s - 10'sd1)
                v = cfg.format_word[fmt2_row[3:0]];
            if (c_s == 8 && r_s >= n_s - 10'sd8 && r_s <= n_s - 10'sd1)
                v = cfg.format_word[fmt2_col[3:0]];
            if (cfg.version_enable) begin
                if (r_s <= 5 && c_s >= ver_s && c_s <= n_s - 10'sd9)
                    v = cfg.version_word[vidx_row];
                if (c_s <= 5 && r_s >= ver_s && r_s <= n_s - 10'sd9)
                    v = cfg.version_word[vidx_col];
            end
        end
        if (r_s >= n_s || c_s >= n_s) v = 1'b0;
    end

    assign module_dark = v;

endmodule
